// ----- hdl/piecewise_linear_curve_lookup_defines.svh -----
// assertion macros for the curve lookup block
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_DEFINES_SVH

// condition must hold in the same cycle
`define PWLCL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwlcl: same-cycle check failed");

// condition must hold in the next cycle
`define PWLCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwlcl: next-cycle check failed");

`endif

// ----- hdl/pwlcl_pkg.sv -----
package pwlcl_pkg;

    localparam int MAX_ROWS   = 6;
    localparam int MIN_ROWS   = 2;
    localparam int NUM_REGS   = MAX_ROWS + 1;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int ADDR_W     = REG_IDX_W + 2;
    localparam int ROW_IDX_W  = $clog2(MAX_ROWS);

    localparam int ROWS_W     = 3;
    localparam int KEY_W      = 16;
    localparam int VAL_W      = 16;
    localparam int ROW_W      = 32;
    localparam int DATA_W     = 32;
    localparam int PCT_W      = 16;

    localparam int PCT_SCALE  = 100;
    localparam int SCALE_W    = $clog2(PCT_SCALE);
    localparam int PROD_W     = 2 * KEY_W;
    localparam int DVD_W      = PROD_W + SCALE_W;
    localparam int QUO_W      = KEY_W + SCALE_W;
    localparam int DIV_STAGES = QUO_W;
    localparam int V2_W       = QUO_W;

    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / PCT_SCALE + 1);

    localparam logic [REG_IDX_W-1:0] REG_ROWS_IN_USE = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_ROW_FIRST   = REG_IDX_W'(1);
    localparam logic [ROWS_W-1:0]    ROWS_RESET      = ROWS_W'(6);

    localparam logic signed [PCT_W-1:0] PCT_MAX = 16'sh7fff;
    localparam logic signed [PCT_W-1:0] PCT_MIN = 16'sh8000;

    typedef struct packed {
        logic             clamp;
        logic             zero_key;
        logic [VAL_W-1:0] base_val;
        logic [KEY_W-1:0] s;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [VAL_W-1:0] v3;
    } sel_t;

    typedef struct packed {
        logic             clamp;
        logic             zero_key;
        logic             neg;
        logic [VAL_W-1:0] base_val;
        logic [KEY_W-1:0] den;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [KEY_W-1:0] op_a;
        logic [KEY_W-1:0] op_b;
    } opd_t;

    typedef struct packed {
        side_t             side;
        logic [PROD_W-1:0] prod;
    } prod_t;

    typedef struct packed {
        side_t            side;
        logic [DVD_W-1:0] dvd;
    } dvd_t;

    typedef struct packed {
        side_t            side;
        logic [KEY_W-1:0] rem;
        logic [QUO_W-1:0] bits;
    } div_t;

    typedef struct packed {
        logic                     clamp;
        logic [VAL_W-1:0]         base_val;
        logic [V2_W-1:0]          v2;
        logic signed [PCT_W-1:0]  pct;
    } post_t;

    function automatic logic [ROW_W-1:0] row_default(input int r);
        logic [ROW_W-1:0] v;
        case (r)
            0:       v = {16'd10000, 16'd5000};
            1:       v = {16'd7600,  16'd3850};
            2:       v = {16'd5200,  16'd2750};
            3:       v = {16'd2600,  16'd1640};
            4:       v = {16'd1300,  16'd1070};
            5:       v = {16'd0,     16'd500};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [KEY_W-1:0] abs_diff(input logic [KEY_W-1:0] a,
                                                  input logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] d;
        if (a >= b)
        begin
            d = a - b;
        end
        else
        begin
            d = b - a;
        end
        return d;
    endfunction

    // one restoring step, one quotient bit
    function automatic div_t div_step(input div_t d);
        div_t           n;
        logic [KEY_W:0] t;
        logic [KEY_W:0] diff;
        n    = d;
        t    = {d.rem, d.bits[QUO_W-1]};
        diff = t - {1'b0, d.side.den};
        if (t >= {1'b0, d.side.den})
        begin
            n.rem  = diff[KEY_W-1:0];
            n.bits = {d.bits[QUO_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = t[KEY_W-1:0];
            n.bits = {d.bits[QUO_W-2:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ----- hdl/piecewise_linear_curve_lookup.sv -----
// channel  dir  handshake                    payload
// in       in   in_valid / in_ready          sample
// out      out  out_valid / out_ready        level_value, overrange_percent
// cfg      in   psel, penable, pwrite        paddr, pwdata; prdata, pready
//
// one transfer per cycle while no untaken result is held at the output
// every result passes through the 23-stage restoring divider, one quotient bit per stage
// a result that is not taken freezes the whole pipeline and holds in_ready low
// reset empties the pipeline and loads the default breakpoint table
`include "piecewise_linear_curve_lookup_defines.svh"

module piecewise_linear_curve_lookup
    import pwlcl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KEY_W-1:0]         sample,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VAL_W-1:0]         level_value,
    output logic signed [PCT_W-1:0]  overrange_percent
);

    localparam int IDX_S1       = 0;
    localparam int IDX_S2       = IDX_S1 + 1;
    localparam int IDX_S3       = IDX_S2 + 1;
    localparam int IDX_S4       = IDX_S3 + 1;
    localparam int IDX_DIV0     = IDX_S4 + 1;
    localparam int IDX_DIV_LAST = IDX_DIV0 + DIV_STAGES - 1;
    localparam int IDX_POST     = IDX_DIV_LAST + 1;
    localparam int IDX_OUT      = IDX_POST + 1;
    localparam int NSTAGE       = IDX_OUT + 1;

    logic [ROWS_W-1:0]         rows_in_use_reg;
    logic [ROW_W-1:0]          row_reg [MAX_ROWS];

    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;

    logic [NSTAGE-1:0]         vld_reg;
    logic                      adv;

    sel_t                      s1_reg, s1_next;
    opd_t                      s2_reg, s2_next;
    prod_t                     s3_reg;
    dvd_t                      s4_reg;
    div_t                      div_reg [DIV_STAGES];
    div_t                      div_init;
    post_t                     post_reg, post_next;
    logic [VAL_W-1:0]          level_reg, level_next;
    logic signed [PCT_W-1:0]   pct_reg;
    logic                      clamp_out_reg;

    logic [ROWS_W-1:0]         rows_eff;
    logic [ROW_IDX_W-1:0]      last;
    logic [ROW_IDX_W-1:0]      pick;
    logic [KEY_W-1:0]          k0;
    logic [KEY_W-1:0]          kl;
    logic [VAL_W-1:0]          vl;
    logic [KEY_W-1:0]          r1;
    logic [KEY_W-1:0]          r3;
    logic [VAL_W-1:0]          v1;
    logic [VAL_W-1:0]          v3;
    logic                      rising;
    logic                      below;
    logic                      above;

    logic [QUO_W-1:0]          quo;
    logic [V2_W-1:0]           base100;
    logic [V2_W:0]             v2_wide;
    logic [V2_W+RECIP_W-1:0]   recip_prod;

    // configuration port

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= ROWS_RESET;
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                row_reg[r] <= row_default(r);
            end
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == REG_ROWS_IN_USE)
            begin
                rows_in_use_reg <= pwdata[ROWS_W-1:0];
            end
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                if (cfg_idx == REG_IDX_W'(r) + REG_ROW_FIRST)
                begin
                    row_reg[r] <= pwdata;
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == REG_ROWS_IN_USE)
        begin
            prdata = DATA_W'(rows_in_use_reg);
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if (cfg_idx == REG_IDX_W'(r) + REG_ROW_FIRST)
            begin
                prdata = row_reg[r];
            end
        end
    end

    // pipeline control

    assign adv       = !vld_reg[IDX_OUT] | out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[IDX_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    // stage 1: clamp detection and bracketing row search

    always_comb
    begin
        rows_eff = rows_in_use_reg;
        if (rows_in_use_reg < ROWS_W'(MIN_ROWS))
        begin
            rows_eff = ROWS_W'(MIN_ROWS);
        end
        else if (rows_in_use_reg > ROWS_W'(MAX_ROWS))
        begin
            rows_eff = ROWS_W'(MAX_ROWS);
        end
        last   = ROW_IDX_W'(rows_eff - ROWS_W'(1));
        k0     = row_reg[0][ROW_W-1:VAL_W];
        rising = row_reg[1][ROW_W-1:VAL_W] > k0;

        kl = '0;
        vl = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if (ROW_IDX_W'(r) == last)
            begin
                kl = row_reg[r][ROW_W-1:VAL_W];
                vl = row_reg[r][VAL_W-1:0];
            end
        end

        below = rising ? (sample <= k0) : (sample >= k0);
        above = rising ? (sample >= kl) : (sample <= kl);

        pick = last;
        for (int r = MAX_ROWS - 1; r >= 1; r--)
        begin
            if (ROW_IDX_W'(r) < last &&
                (rising ? (row_reg[r][ROW_W-1:VAL_W] >= sample)
                        : (row_reg[r][ROW_W-1:VAL_W] <= sample)))
            begin
                pick = ROW_IDX_W'(r);
            end
        end

        r1 = '0;
        v1 = '0;
        r3 = '0;
        v3 = '0;
        for (int r = 1; r < MAX_ROWS; r++)
        begin
            if (ROW_IDX_W'(r) == pick)
            begin
                r1 = row_reg[r][ROW_W-1:VAL_W];
                v1 = row_reg[r][VAL_W-1:0];
                r3 = row_reg[r-1][ROW_W-1:VAL_W];
                v3 = row_reg[r-1][VAL_W-1:0];
            end
        end

        s1_next.s     = sample;
        s1_next.key_b = r3;
        s1_next.v3    = v3;
        if (below)
        begin
            s1_next.clamp    = 1'b1;
            s1_next.base_val = row_reg[0][VAL_W-1:0];
            s1_next.key_a    = k0;
        end
        else if (above)
        begin
            s1_next.clamp    = 1'b1;
            s1_next.base_val = vl;
            s1_next.key_a    = kl;
        end
        else
        begin
            s1_next.clamp    = 1'b0;
            s1_next.base_val = v1;
            s1_next.key_a    = r1;
        end
        s1_next.zero_key = (s1_next.key_a == '0);
    end

    // stage 2: magnitudes and quotient sign

    always_comb
    begin
        s2_next.side.clamp    = s1_reg.clamp;
        s2_next.side.zero_key = s1_reg.zero_key;
        s2_next.side.base_val = s1_reg.base_val;
        s2_next.op_a          = abs_diff(s1_reg.s, s1_reg.key_a);
        if (s1_reg.clamp)
        begin
            s2_next.op_b     = KEY_W'(1);
            s2_next.side.den = s1_reg.zero_key ? KEY_W'(1) : s1_reg.key_a;
            s2_next.side.neg = s1_reg.s < s1_reg.key_a;
        end
        else
        begin
            s2_next.op_b     = abs_diff(s1_reg.v3, s1_reg.base_val);
            s2_next.side.den = abs_diff(s1_reg.key_b, s1_reg.key_a);
            s2_next.side.neg = (s1_reg.s < s1_reg.key_a)
                             ^ (s1_reg.v3 < s1_reg.base_val)
                             ^ (s1_reg.key_b < s1_reg.key_a);
        end
    end

    assign div_init.side = s4_reg.side;
    assign div_init.rem  = s4_reg.dvd[DVD_W-1:QUO_W];
    assign div_init.bits = s4_reg.dvd[QUO_W-1:0];

    // post stage: sign, saturation and rescale

    assign quo     = div_reg[DIV_STAGES-1].bits;
    assign base100 = {{(V2_W-VAL_W){1'b0}}, div_reg[DIV_STAGES-1].side.base_val}
                   * V2_W'(PCT_SCALE);

    always_comb
    begin
        post_next.clamp    = div_reg[DIV_STAGES-1].side.clamp;
        post_next.base_val = div_reg[DIV_STAGES-1].side.base_val;
        if (div_reg[DIV_STAGES-1].side.neg)
        begin
            v2_wide = {1'b0, base100} - {1'b0, quo};
        end
        else
        begin
            v2_wide = {1'b0, base100} + {1'b0, quo};
        end
        post_next.v2 = v2_wide[V2_W-1:0];

        if (!div_reg[DIV_STAGES-1].side.clamp || div_reg[DIV_STAGES-1].side.zero_key)
        begin
            post_next.pct = '0;
        end
        else if (div_reg[DIV_STAGES-1].side.neg)
        begin
            if (quo >= QUO_W'(32768))
            begin
                post_next.pct = PCT_MIN;
            end
            else
            begin
                post_next.pct = -$signed(quo[PCT_W-1:0]);
            end
        end
        else
        begin
            if (quo > QUO_W'(32767))
            begin
                post_next.pct = PCT_MAX;
            end
            else
            begin
                post_next.pct = $signed(quo[PCT_W-1:0]);
            end
        end
    end

    // divide by the percent scale through a reciprocal

    assign recip_prod = {{RECIP_W{1'b0}}, post_reg.v2} * {{V2_W{1'b0}}, RECIP};
    assign level_next = post_reg.clamp ? post_reg.base_val
                                       : recip_prod[RECIP_SHIFT +: VAL_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg          <= s1_next;
            s2_reg          <= s2_next;
            s3_reg.side     <= s2_reg.side;
            s3_reg.prod     <= {{KEY_W{1'b0}}, s2_reg.op_a} * {{KEY_W{1'b0}}, s2_reg.op_b};
            s4_reg.side     <= s3_reg.side;
            s4_reg.dvd      <= {{SCALE_W{1'b0}}, s3_reg.prod} * DVD_W'(PCT_SCALE);
            div_reg[0]      <= div_step(div_init);
            for (int j = 1; j < DIV_STAGES; j++)
            begin
                div_reg[j] <= div_step(div_reg[j-1]);
            end
            post_reg        <= post_next;
            level_reg       <= level_next;
            pct_reg         <= post_reg.pct;
            clamp_out_reg   <= post_reg.clamp;
        end
    end

    assign level_value       = level_reg;
    assign overrange_percent = pct_reg;

    `PWLCL_ASSERT_NEXT(a_accept_enters_pipe, in_valid && in_ready, vld_reg[IDX_S1])
    `PWLCL_ASSERT_NOW(a_div_rem_below_den, vld_reg[IDX_DIV_LAST],
        div_reg[DIV_STAGES-1].rem < div_reg[DIV_STAGES-1].side.den)
    `PWLCL_ASSERT_NOW(a_inside_no_overrange, out_valid && !clamp_out_reg,
        overrange_percent == '0)

endmodule

// ----- bench/tb_piecewise_linear_curve_lookup.sv -----
`timescale 1ns / 1ps

module tb_piecewise_linear_curve_lookup;
    import pwlcl_pkg::*;

    localparam int MAX_IDLE     = 12;
    localparam int LONG_HOLD    = 90;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;

    localparam logic [REG_IDX_W-1:0] REG_ROW0   = REG_ROW_FIRST;
    localparam logic [REG_IDX_W-1:0] REG_ROW1   = REG_IDX_W'(REG_ROW_FIRST + 1);
    localparam logic [REG_IDX_W-1:0] REG_ROW2   = REG_IDX_W'(REG_ROW_FIRST + 2);
    localparam logic [REG_IDX_W-1:0] REG_ROW3   = REG_IDX_W'(REG_ROW_FIRST + 3);
    localparam logic [REG_IDX_W-1:0] REG_ROW4   = REG_IDX_W'(REG_ROW_FIRST + 4);
    localparam logic [REG_IDX_W-1:0] REG_ROW5   = REG_IDX_W'(REG_ROW_FIRST + 5);
    localparam logic [REG_IDX_W-1:0] REG_BEYOND = REG_IDX_W'(NUM_REGS);

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;
    typedef enum int {SHAPE_RISING, SHAPE_FALLING, SHAPE_SCRAMBLED} curve_shape_t;

    typedef struct packed {
        logic [VAL_W-1:0]        lvl;
        logic signed [PCT_W-1:0] pct;
    } level_t;

    typedef struct packed {
        step_kind_t              kind;
        logic [REG_IDX_W-1:0]    reg_idx;
        logic [DATA_W-1:0]       data;
        logic                    typed;
        logic [VAL_W-1:0]        lvl;
        logic signed [PCT_W-1:0] pct;
    } directed_step_t;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_ready;
    logic [KEY_W-1:0]        sample;
    logic                    out_valid;
    logic                    out_ready;
    logic [VAL_W-1:0]        level_value;
    logic signed [PCT_W-1:0] overrange_percent;

    logic [ROWS_W-1:0] rows_cfg;
    logic [ROW_W-1:0]  curve_row [MAX_ROWS];
    level_t            pending_levels [$];
    int                mismatches;
    int                quiet_cycles;
    bit                tx_idle;
    bit                rx_idle;
    bit                rx_long_hold;

    piecewise_linear_curve_lookup dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample            (sample),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .level_value       (level_value),
        .overrange_percent (overrange_percent)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int used_rows();
        int n;
        n = int'(rows_cfg);
        if (n < MIN_ROWS)
        begin
            n = MIN_ROWS;
        end
        if (n > MAX_ROWS)
        begin
            n = MAX_ROWS;
        end
        return n;
    endfunction

    function automatic longint key_at(input int r);
        return longint'(curve_row[r][ROW_W-1:VAL_W]);
    endfunction

    function automatic longint value_at(input int r);
        return longint'(curve_row[r][VAL_W-1:0]);
    endfunction

    function automatic logic signed [PCT_W-1:0] overrange(input longint s, input longint k);
        longint p;
        if (k == 0)
        begin
            return '0;
        end
        p = ((s - k) * PCT_SCALE) / k;
        if (p > 32767)
        begin
            p = 32767;
        end
        if (p < -32768)
        begin
            p = -32768;
        end
        return PCT_W'(p);
    endfunction

    function automatic level_t curve_eval(input logic [KEY_W-1:0] s_in);
        level_t r;
        longint s;
        longint k0;
        longint kl;
        longint r1;
        longint r3;
        longint v1;
        longint v3;
        longint v2;
        int     last;
        int     i;
        bit     rising;
        s      = longint'(s_in);
        last   = used_rows() - 1;
        k0     = key_at(0);
        kl     = key_at(last);
        rising = key_at(1) > k0;
        r.pct  = '0;
        if (rising ? (s <= k0) : (s >= k0))
        begin
            r.lvl = VAL_W'(value_at(0));
            r.pct = overrange(s, k0);
        end
        else if (rising ? (s >= kl) : (s <= kl))
        begin
            r.lvl = VAL_W'(value_at(last));
            r.pct = overrange(s, kl);
        end
        else
        begin
            i = 1;
            while (i < last && (rising ? (key_at(i) < s) : (key_at(i) > s)))
            begin
                i++;
            end
            r1 = key_at(i);
            r3 = key_at(i - 1);
            v1 = value_at(i);
            v3 = value_at(i - 1);
            if (r3 == r1)
            begin
                v2 = PCT_SCALE * v1;
            end
            else
            begin
                v2 = ((PCT_SCALE * ((s - r1) * (v3 - v1))) / (r3 - r1)) + PCT_SCALE * v1;
            end
            r.lvl = VAL_W'(v2 / PCT_SCALE);
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_sample();
        int               n;
        int               k;
        int unsigned      roll;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        logic [KEY_W-1:0] kk;
        n  = used_rows();
        lo = '1;
        hi = '0;
        for (k = 0; k < n; k++)
        begin
            kk = KEY_W'(key_at(k));
            if (kk < lo)
            begin
                lo = kk;
            end
            if (kk > hi)
            begin
                hi = kk;
            end
        end
        roll = $urandom_range(0, 19);
        if (roll < 12)
        begin
            return KEY_W'($urandom_range(lo, hi));
        end
        if (roll < 16)
        begin
            kk = KEY_W'(key_at($urandom_range(0, n - 1)));
            return kk + KEY_W'($urandom_range(0, 2)) - KEY_W'(1);
        end
        return KEY_W'($urandom);
    endfunction

    function automatic int tx_gap();
        return tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic directed_step_t cfg_step(input logic [REG_IDX_W-1:0] idx,
                                                input logic [DATA_W-1:0] val);
        directed_step_t d;
        d         = '0;
        d.kind    = STEP_WRITE;
        d.reg_idx = idx;
        d.data    = val;
        return d;
    endfunction

    function automatic directed_step_t known_step(input logic [KEY_W-1:0] s,
                                                  input logic [VAL_W-1:0] lvl,
                                                  input logic signed [PCT_W-1:0] pct);
        directed_step_t d;
        d       = '0;
        d.kind  = STEP_SAMPLE;
        d.data  = DATA_W'(s);
        d.typed = 1'b1;
        d.lvl   = lvl;
        d.pct   = pct;
        return d;
    endfunction

    function automatic directed_step_t checked_step(input logic [KEY_W-1:0] s);
        directed_step_t d;
        d      = '0;
        d.kind = STEP_SAMPLE;
        d.data = DATA_W'(s);
        return d;
    endfunction

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ROWS_IN_USE)
        begin
            rows_cfg = val[ROWS_W-1:0];
        end
        else if (idx < NUM_REGS)
        begin
            curve_row[idx - REG_ROW_FIRST] = val;
        end
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [KEY_W-1:0] s, input int gap, input logic typed,
                               input logic [VAL_W-1:0] lvl, input logic signed [PCT_W-1:0] pct);
        level_t want;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            want.lvl = lvl;
            want.pct = pct;
        end
        else
        begin
            want = curve_eval(s);
        end
        pending_levels.push_back(want);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_random_curve(input curve_shape_t shape);
        logic [KEY_W-1:0]  keys [$];
        logic [DATA_W-1:0] word;
        int                span;
        int                k;
        span = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(8, 3000);
        for (k = 0; k < MAX_ROWS; k++)
        begin
            keys.push_back(KEY_W'($urandom_range(0, span)));
        end
        if (shape == SHAPE_RISING)
        begin
            keys.sort();
        end
        else if (shape == SHAPE_FALLING)
        begin
            keys.rsort();
        end
        cfg_write(REG_ROWS_IN_USE, DATA_W'($urandom_range(0, 7)));
        for (k = 0; k < MAX_ROWS; k++)
        begin
            if (shape == SHAPE_SCRAMBLED)
            begin
                word = $urandom;
            end
            else
            begin
                word = {keys[k], VAL_W'($urandom)};
            end
            cfg_write(REG_IDX_W'(REG_ROW_FIRST + k), word);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_write(REG_BEYOND, $urandom);
        end
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            if (rx_long_hold)
            begin
                stall        = LONG_HOLD;
                rx_long_hold = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        level_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transfer, level_value %0d overrange_percent %0d",
                         $time, level_value, overrange_percent);
            end
            else
            begin
                want = pending_levels.pop_front();
                if (level_value !== want.lvl)
                begin
                    mismatches++;
                    $display("%0t: level_value expected %0d actual %0d",
                             $time, want.lvl, level_value);
                end
                if (overrange_percent !== want.pct)
                begin
                    mismatches++;
                    $display("%0t: overrange_percent expected %0d actual %0d",
                             $time, want.pct, overrange_percent);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        directed_step_t script [$];
        bit             prev_write;
        int             phase;
        int             item;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        sample       = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_long_hold = 1'b0;
        rows_cfg     = ROWS_RESET;
        curve_row[0] = {16'd10000, 16'd5000};
        curve_row[1] = {16'd7600,  16'd3850};
        curve_row[2] = {16'd5200,  16'd2750};
        curve_row[3] = {16'd2600,  16'd1640};
        curve_row[4] = {16'd1300,  16'd1070};
        curve_row[5] = {16'd0,     16'd500};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        script = '{
            // default falling table
            known_step(16'hFFFF, 16'd5000, 16'sd555),
            known_step(16'd10000, 16'd5000, 16'sd0),
            known_step(16'd0, 16'd500, 16'sd0),
            known_step(16'd7600, 16'd3850, 16'sd0),
            known_step(16'd5200, 16'd2750, 16'sd0),
            checked_step(16'd9999),
            checked_step(16'd1),
            // two-row rising table
            cfg_step(REG_ROWS_IN_USE, 32'd2),
            cfg_step(REG_ROW0, {16'd100, 16'd10}),
            cfg_step(REG_ROW1, {16'd200, 16'd20}),
            known_step(16'd0, 16'd10, -16'sd100),
            known_step(16'd100, 16'd10, 16'sd0),
            checked_step(16'd150),
            known_step(16'd200, 16'd20, 16'sd0),
            known_step(16'hFFFF, 16'd20, 16'sd32667),
            // tiny end key, percent saturates
            cfg_step(REG_ROW0, {16'd1, 16'd0}),
            cfg_step(REG_ROW1, {16'd2, 16'hFFFF}),
            known_step(16'hFFFF, 16'hFFFF, 16'sd32767),
            known_step(16'd0, 16'd0, -16'sd100),
            // full-scale falling table
            cfg_step(REG_ROW0, 32'hFFFF_FFFF),
            cfg_step(REG_ROW1, 32'h0000_0000),
            known_step(16'hFFFF, 16'hFFFF, 16'sd0),
            known_step(16'd0, 16'd0, 16'sd0),
            checked_step(16'd32768),
            // zero row count, equal zero keys
            cfg_step(REG_ROWS_IN_USE, 32'd0),
            cfg_step(REG_ROW0, {16'd0, 16'h1234}),
            cfg_step(REG_ROW1, {16'd0, 16'h5678}),
            known_step(16'd0, 16'h1234, 16'sd0),
            known_step(16'hFFFF, 16'h1234, 16'sd0),
            // default rows back, row count one then seven
            cfg_step(REG_ROWS_IN_USE, 32'd1),
            cfg_step(REG_ROW0, {16'd10000, 16'd5000}),
            cfg_step(REG_ROW1, {16'd7600, 16'd3850}),
            cfg_step(REG_ROW2, {16'd5200, 16'd2750}),
            cfg_step(REG_ROW3, {16'd2600, 16'd1640}),
            cfg_step(REG_ROW4, {16'd1300, 16'd1070}),
            cfg_step(REG_ROW5, {16'd0, 16'd500}),
            known_step(16'd0, 16'd3850, -16'sd100),
            known_step(16'hFFFF, 16'd5000, 16'sd555),
            cfg_step(REG_ROWS_IN_USE, 32'd7),
            cfg_step(REG_BEYOND, 32'hFFFF_FFFF),
            known_step(16'd0, 16'd500, 16'sd0),
            checked_step(16'd5000),
            checked_step(16'd12000)
        };

        prev_write = 1'b0;
        foreach (script[i])
        begin
            if (script[i].kind == STEP_WRITE)
            begin
                if (!prev_write)
                begin
                    drain_pipeline();
                end
                cfg_write(script[i].reg_idx, script[i].data);
                prev_write = 1'b1;
            end
            else
            begin
                send_sample(script[i].data[KEY_W-1:0], tx_gap(), script[i].typed,
                            script[i].lvl, script[i].pct);
                prev_write = 1'b0;
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_pipeline();
            load_random_curve(curve_shape_t'($urandom_range(0, 2)));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                // back-to-back samples against a long result hold-off
                tx_idle      = 1'b0;
                rx_long_hold = 1'b1;
            end
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                send_sample(pick_sample(), tx_gap(), 1'b0, '0, '0);
            end
        end

        drain_pipeline();
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
